// File: rtl/iwpd_pkg.sv
// Shared types, constants and helpers for the IR window peak / wall detector.
// Used by iwpd_lane and ir_window_peak_wall_detector; depends on nothing else.
package iwpd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 3;

  // Stream payload widths
  localparam int IN_DATA_W  = 40;  // 3 x 12 bit samples, padded to whole bytes
  localparam int OUT_DATA_W = 56;  // 4 peaks, 4 wall flags, start, battery level

  // Battery thresholds: sample * 3.3 / 4096 * 3 >= 4, 5, 6, 7 V
  localparam logic [SAMPLE_W-1:0] BAT_T4 = 12'd1655;
  localparam logic [SAMPLE_W-1:0] BAT_T5 = 12'd2069;
  localparam logic [SAMPLE_W-1:0] BAT_T6 = 12'd2483;
  localparam logic [SAMPLE_W-1:0] BAT_T7 = 12'd2897;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    OP_FRONT = 1'b0,
    OP_SIDE  = 1'b1
  } op_e;

  typedef enum logic {
    REG_WALL_THR  = 1'b0,
    REG_START_THR = 1'b1
  } reg_idx_e;

  // Depth of the max tree; at least one registered level.
  function automatic int tree_levels(input int window);
    tree_levels = (window > 1) ? $clog2(window) : 1;
  endfunction

  function automatic logic [LEVEL_W-1:0] battery_grade(input sample_t s);
    logic [LEVEL_W-1:0] n;
    n = {2'b00, s >= BAT_T4} + {2'b00, s >= BAT_T5}
      + {2'b00, s >= BAT_T6} + {2'b00, s >= BAT_T7};
    return n;
  endfunction

endpackage

// File: rtl/ir_window_peak_wall_detector.sv
// Top level of the four-channel IR window peak / wall detector: stream ports,
// lane instances, merge stage and output register. Depends on iwpd_pkg, iwpd_lane.
//
// Usage:
//  - Input beats on s_axis: tuser selects the pair (0 front pair plus battery,
//    1 side pair), tdata carries left, right and battery samples.
//  - Each accepted beat shifts its pair into two of the four channel windows
//    (front left/right or side left/right) and yields exactly one output beat
//    on m_axis with the four window maxima, the wall flags, the start flag and
//    the battery level of the last front beat.
//  - Config: cfg_we_i writes cfg_wdata_i to the wall (index 0) or start
//    (index 1) threshold; write only while the block is idle.
//  - Throughput: one beat per cycle while the output is not stalled. Path: an
//    accepted beat passes its lane windows, the LEVELS = max(1, clog2(WINDOW))
//    registered levels of the max tree in each lane, then the output register.
//  - Reset clears windows, thresholds, battery reading and all valid bits.
//  - Stall: when the output register is full and m_axis_tready_i is low, the
//    whole pipeline holds and s_axis_tready_o drops; nothing is lost.
module ir_window_peak_wall_detector #(
  parameter int WINDOW = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [11:0] left_sample, [23:12] right_sample, [35:24] battery_sample, [39:36] zero
  input  logic [iwpd_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] operation
  input  logic                            s_axis_tuser_i,
  // output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [11:0] peak_front_left, [23:12] peak_front_right, [35:24] peak_side_left,
  // [47:36] peak_side_right, [48] wall_front_left, [49] wall_front_right,
  // [50] wall_side_left, [51] wall_side_right, [52] start_ready,
  // [55:53] battery_level
  output logic [iwpd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // config write port
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [iwpd_pkg::SAMPLE_W-1:0]   cfg_wdata_i
);
  import iwpd_pkg::*;

  localparam int LEVELS = tree_levels(WINDOW);

  // Pipeline advance: output register empty or being drained
  logic en, in_acc, push_front, push_side;
  logic out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  sample_t left_s, right_s, bat_s;
  sample_t wall_thr_q, start_thr_q;

  logic [LEVELS:0] vld_q;     // [0]: beat sits in windows, [k]: at tree level k
  sample_t bat_q [LEVELS+1];  // battery reading travelling with each beat

  sample_t pk_fl, pk_fr, pk_sl, pk_sr;
  logic [3:0] wall;
  logic start;
  logic [LEVEL_W-1:0] bat_lvl;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign in_acc          = s_axis_tvalid_i && en;

  assign left_s  = s_axis_tdata_i[SAMPLE_W-1:0];
  assign right_s = s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W];
  assign bat_s   = s_axis_tdata_i[3*SAMPLE_W-1:2*SAMPLE_W];

  assign push_front = in_acc && (op_e'(s_axis_tuser_i) == OP_FRONT);
  assign push_side  = in_acc && (op_e'(s_axis_tuser_i) == OP_SIDE);

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_thr_q  <= '0;
      start_thr_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WALL_THR:  wall_thr_q  <= cfg_wdata_i;
        REG_START_THR: start_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Lanes: one per channel
  iwpd_lane #(.WINDOW(WINDOW)) u_lane_fl (
    .clk_i, .rst_ni, .en_i(en), .push_i(push_front), .sample_i(left_s),  .peak_o(pk_fl)
  );
  iwpd_lane #(.WINDOW(WINDOW)) u_lane_fr (
    .clk_i, .rst_ni, .en_i(en), .push_i(push_front), .sample_i(right_s), .peak_o(pk_fr)
  );
  iwpd_lane #(.WINDOW(WINDOW)) u_lane_sl (
    .clk_i, .rst_ni, .en_i(en), .push_i(push_side),  .sample_i(left_s),  .peak_o(pk_sl)
  );
  iwpd_lane #(.WINDOW(WINDOW)) u_lane_sr (
    .clk_i, .rst_ni, .en_i(en), .push_i(push_side),  .sample_i(right_s), .peak_o(pk_sr)
  );

  // Last battery reading is state; later stages just follow the tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LEVELS; k++) bat_q[k] <= '0;
    end else begin
      if (push_front) begin
        bat_q[0] <= bat_s;
      end
      if (en) begin
        for (int k = 1; k <= LEVELS; k++) bat_q[k] <= bat_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LEVELS-1:0], in_acc};
    end
  end

  // Merge stage: flags and battery grade on the tree roots
  always_comb begin
    wall[0] = pk_fl > wall_thr_q;
    wall[1] = pk_fr > wall_thr_q;
    wall[2] = pk_sl > wall_thr_q;
    wall[3] = pk_sr > wall_thr_q;
    start   = (pk_sl > start_thr_q) && (pk_sr > start_thr_q);
    bat_lvl = battery_grade(bat_q[LEVELS]);
    out_data_d = {bat_lvl, start, wall, pk_sr, pk_sl, pk_fr, pk_fl};
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[LEVELS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: rtl/iwpd_lane.sv
// One channel lane: a WINDOW-deep sample shift line and a pipelined max tree.
// Depends on iwpd_pkg.
module iwpd_lane #(
  parameter int WINDOW = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,      // pipeline advance
  input  logic                      push_i,    // shift a new sample in
  input  logic [iwpd_pkg::SAMPLE_W-1:0] sample_i,
  output logic [iwpd_pkg::SAMPLE_W-1:0] peak_o
);
  import iwpd_pkg::*;

  localparam int LEVELS = tree_levels(WINDOW);
  localparam int NPAD   = 1 << LEVELS;
  localparam int NODES  = NPAD - 1;

  sample_t win_q  [WINDOW];
  sample_t leaf   [NPAD];
  sample_t node_q [NODES];

  // Window: newest sample at index 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
    end else if (push_i) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < WINDOW; i++) win_q[i] <= win_q[i-1];
    end
  end

  // Pad to a power of two with zeros (zero never raises a max)
  for (genvar i = 0; i < NPAD; i++) begin : g_leaf
    if (i < WINDOW) begin : g_tap
      assign leaf[i] = win_q[i];
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // Heap-ordered tree, node n has children 2n+1 and 2n+2; every level registered
  for (genvar n = 0; n < NODES; n++) begin : g_node
    sample_t a, b;
    if (2*n + 1 >= NODES) begin : g_from_leaf
      assign a = leaf[2*n + 1 - NODES];
      assign b = leaf[2*n + 2 - NODES];
    end else begin : g_from_node
      assign a = node_q[2*n + 1];
      assign b = node_q[2*n + 2];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        node_q[n] <= (a > b) ? a : b;
      end
    end
  end

  assign peak_o = node_q[0];

endmodule

// File: bench/iwpd_peak_checker.sv
// Checker for the IR window peak / wall detector: watches both stream channels
// and the config port, predicts every output beat and compares it field by field.
// Depends on iwpd_pkg.
module iwpd_peak_checker #(
  parameter int WINDOW = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [iwpd_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  logic                            s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [iwpd_pkg::OUT_DATA_W-1:0] m_tdata_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  iwpd_pkg::sample_t               cfg_wdata_i,
  output int                              outstanding_o,
  output int                              fail_count_o
);
  import iwpd_pkg::*;

  localparam int NUM_CH = 4;
  localparam int CH_FL  = 0;
  localparam int CH_FR  = 1;
  localparam int CH_SL  = 2;
  localparam int CH_SR  = 3;

  // laid out MSB first so a cast of m_tdata matches the port layout
  typedef struct packed {
    logic [LEVEL_W-1:0] battery_level;
    logic               start_ready;
    logic               wall_side_right;
    logic               wall_side_left;
    logic               wall_front_right;
    logic               wall_front_left;
    sample_t            peak_side_right;
    sample_t            peak_side_left;
    sample_t            peak_front_right;
    sample_t            peak_front_left;
  } peak_report_t;

  sample_t      windows [NUM_CH][WINDOW];
  sample_t      wall_thr;
  sample_t      start_thr;
  sample_t      battery_last;
  peak_report_t report_q [$];
  int           shown;
  string        field_names [10] = '{"peak_front_left", "peak_front_right",
                                     "peak_side_left", "peak_side_right",
                                     "wall_front_left", "wall_front_right",
                                     "wall_side_left", "wall_side_right",
                                     "start_ready", "battery_level"};

  function automatic logic [LEVEL_W-1:0] supply_level(sample_t s);
    logic [LEVEL_W-1:0] n;
    n = '0;
    if (s >= BAT_T4) n++;
    if (s >= BAT_T5) n++;
    if (s >= BAT_T6) n++;
    if (s >= BAT_T7) n++;
    return n;
  endfunction

  function automatic sample_t window_max(int ch);
    sample_t m;
    m = '0;
    for (int j = 0; j < WINDOW; j++)
      if (windows[ch][j] > m) m = windows[ch][j];
    return m;
  endfunction

  // shift the pair into its windows, then derive the whole output beat
  function automatic peak_report_t advance_and_predict(op_e op, sample_t l, sample_t r,
                                                       sample_t b);
    peak_report_t rep;
    int           ch_l;
    ch_l = (op == OP_FRONT) ? CH_FL : CH_SL;
    for (int j = WINDOW - 1; j > 0; j--) begin
      windows[ch_l][j]     = windows[ch_l][j-1];
      windows[ch_l + 1][j] = windows[ch_l + 1][j-1];
    end
    windows[ch_l][0]     = l;
    windows[ch_l + 1][0] = r;
    if (op == OP_FRONT) battery_last = b;
    rep.peak_front_left  = window_max(CH_FL);
    rep.peak_front_right = window_max(CH_FR);
    rep.peak_side_left   = window_max(CH_SL);
    rep.peak_side_right  = window_max(CH_SR);
    rep.wall_front_left  = rep.peak_front_left > wall_thr;
    rep.wall_front_right = rep.peak_front_right > wall_thr;
    rep.wall_side_left   = rep.peak_side_left > wall_thr;
    rep.wall_side_right  = rep.peak_side_right > wall_thr;
    rep.start_ready      = (rep.peak_side_left > start_thr) &&
                           (rep.peak_side_right > start_thr);
    rep.battery_level    = supply_level(battery_last);
    return rep;
  endfunction

  task automatic check_beat(logic [OUT_DATA_W-1:0] data);
    peak_report_t got;
    peak_report_t want;
    logic [11:0]  got_f [10];
    logic [11:0]  want_f [10];
    got = data;
    if (report_q.size() == 0) begin
      fail_count_o++;
      if (shown < 10) $display("unexpected output beat, data %h", data);
      shown++;
      return;
    end
    want   = report_q.pop_front();
    got_f  = '{got.peak_front_left, got.peak_front_right, got.peak_side_left,
               got.peak_side_right, 12'(got.wall_front_left),
               12'(got.wall_front_right), 12'(got.wall_side_left),
               12'(got.wall_side_right), 12'(got.start_ready),
               12'(got.battery_level)};
    want_f = '{want.peak_front_left, want.peak_front_right, want.peak_side_left,
               want.peak_side_right, 12'(want.wall_front_left),
               12'(want.wall_front_right), 12'(want.wall_side_left),
               12'(want.wall_side_right), 12'(want.start_ready),
               12'(want.battery_level)};
    for (int i = 0; i < 10; i++) begin
      if (got_f[i] !== want_f[i]) begin
        fail_count_o++;
        if (shown < 10)
          $display("%s mismatch: expected %0d, got %0d", field_names[i], want_f[i],
                   got_f[i]);
        shown++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CH; c++)
        for (int j = 0; j < WINDOW; j++) windows[c][j] = '0;
      wall_thr      = '0;
      start_thr     = '0;
      battery_last  = '0;
      report_q.delete();
      shown         = 0;
      fail_count_o  = 0;
      outstanding_o <= 0;
    end else begin
      // drain before fill: a result can never leave in the cycle its beat enters
      if (m_tvalid_i && m_tready_i) check_beat(m_tdata_i);
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_WALL_THR:  wall_thr = cfg_wdata_i;
          REG_START_THR: start_thr = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        report_q.push_back(advance_and_predict(op_e'(s_tuser_i), s_tdata_i[11:0],
                                               s_tdata_i[23:12], s_tdata_i[35:24]));
      outstanding_o <= report_q.size();
    end
  end

endmodule

// File: bench/ir_window_peak_wall_detector_tb.sv
// Top of the IR window peak / wall detector bench: clock, reset, stimulus and
// verdict. Depends on iwpd_pkg, ir_window_peak_wall_detector and iwpd_peak_checker.
module ir_window_peak_wall_detector_tb;
  import iwpd_pkg::*;

  localparam int WINDOW       = 4;
  localparam int PIPE_LATENCY = 3;  // matches the DUT pipeline for a window of four

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [11:0] left, [23:12] right, [35:24] battery, [39:36] zero
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // [0] operation
  logic                  s_tuser = OP_FRONT;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [47:0] four peaks, [51:48] wall flags, [52] start, [55:53] battery level
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic                  cfg_idx = REG_WALL_THR;
  sample_t               cfg_wdata = '0;
  int                    outstanding;
  int                    fail_count;

  // sender burst bookkeeping and the thresholds in force, for near-edge values
  int                    burst_left = 0;
  sample_t               cur_wall = '0;
  sample_t               cur_start = '0;

  // receiver stall pattern: a mode held for a random stretch of cycles
  int                    stall_mode = 0;
  int                    stall_cnt = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ir_window_peak_wall_detector #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  iwpd_peak_checker #(
    .WINDOW(WINDOW)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count)
  );

  // Receiver: always ready, coin flip, mostly stalled, or long on/off blocks.
  // Each mode holds until a random countdown runs out, so stalls land on every pipeline phase.
  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt  = $urandom_range(16, 80);
    end else begin
      stall_cnt = stall_cnt - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= stall_cnt[3];
    endcase
  end

  // Value a few counts either side of an edge, clamped to the 12-bit range.
  function automatic sample_t near(sample_t edge_val);
    int v;
    v = int'(edge_val) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  // Half the time near a live threshold so wall and start flags toggle, with extremes
  // and full-range values mixed in to exercise every sample bit.
  function automatic sample_t pick_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:          return '0;
      1:          return '1;
      2, 3, 4:    return near(cur_wall);
      5, 6:       return near(cur_start);
      default:    return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic sample_t pick_battery();
    case ($urandom_range(0, 5))
      0:       return near(BAT_T4);
      1:       return near(BAT_T5);
      2:       return near(BAT_T6);
      3:       return near(BAT_T7);
      default: return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  // Offer one beat and hold it until the block takes it. At the start of a
  // burst valid may drop for a random gap; otherwise it stays high back to back.
  task automatic send_beat(op_e op, sample_t l, sample_t r, sample_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, b, r, l};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Thresholds change only with the pipe empty: stop offering, wait for every
  // expected beat, let the latency pass, then write both registers.
  task automatic set_thresholds(sample_t wall, sample_t start);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_WALL_THR;
    cfg_wdata <= wall;
    @(posedge clk_i);
    cfg_idx   <= REG_START_THR;
    cfg_wdata <= start;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_wall  = wall;
    cur_start = start;
  endtask

  initial begin
    sample_t wall_set [6];
    sample_t start_set [6];
    sample_t bat_edges [8];
    op_e     op;

    wall_set  = '{12'd4095, 12'd0, 12'd2000, 12'd0, 12'd4095, 12'd0};
    start_set = '{12'd4095, 12'd0, 12'd1000, 12'd4095, 12'd0, 12'd0};
    bat_edges = '{12'd1654, 12'd1655, 12'd2068, 12'd2069, 12'd2482, 12'd2483,
                  12'd2896, 12'd2897};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset thresholds of zero. Fresh windows still hold zeros, so
    // an all-zero front beat must report no wall and no start.
    send_beat(OP_FRONT, 12'd0, 12'd0, 12'd0);
    send_beat(OP_FRONT, 12'hFFF, 12'hFFF, 12'hFFF);
    // side beats carry a battery field that must be ignored
    send_beat(OP_SIDE, 12'hFFF, 12'hFFF, 12'd0);
    send_beat(OP_SIDE, 12'hAAA, 12'h555, 12'h555);
    send_beat(OP_FRONT, 12'h555, 12'hAAA, 12'hAAA);
    // battery level steps, at each edge and one count below it
    foreach (bat_edges[i])
      send_beat(OP_FRONT, sample_t'(i), sample_t'(7 - i), bat_edges[i]);
    send_beat(OP_SIDE, 12'd0, 12'd0, 12'hFFF);

    // Flags right at the thresholds once the old maxima have aged out.
    set_thresholds(12'd2000, 12'd1000);
    send_beat(OP_SIDE, 12'd1000, 12'd1001, 12'd0);
    send_beat(OP_SIDE, 12'd1001, 12'd1000, 12'd0);
    send_beat(OP_SIDE, 12'd1001, 12'd1001, 12'd0);
    send_beat(OP_SIDE, 12'd1000, 12'd1000, 12'd0);
    send_beat(OP_FRONT, 12'd2000, 12'd2001, 12'd0);

    // Random phases over several threshold settings, extremes included; the
    // last two phases draw fresh random thresholds.
    for (int p = 0; p < 6; p++) begin
      if (p < 4) set_thresholds(wall_set[p], start_set[p]);
      else set_thresholds(sample_t'($urandom_range(0, 4095)),
                          sample_t'($urandom_range(0, 4095)));
      repeat (100) begin
        op = op_e'($urandom_range(0, 1));
        send_beat(op, pick_sample(), pick_sample(), pick_battery());
      end
    end

    // Drain, then give the pipe time to show any stray beat.
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4 * PIPE_LATENCY) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ir_window_peak_wall_detector_tb passed");
    end else begin
      $display("ir_window_peak_wall_detector_tb failed");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run of ~650 beats with stalls.
  initial begin
    #2000000;
    $display("ir_window_peak_wall_detector_tb failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/iwpd_pkg.sv
rtl/iwpd_lane.sv
rtl/ir_window_peak_wall_detector.sv
bench/iwpd_peak_checker.sv
bench/ir_window_peak_wall_detector_tb.sv
